>>> hdl/mono_page_framebuffer_plot_unit_assert.svh
// Assertion macros for the port-level checker of the framebuffer plot unit.
`ifndef MONO_PAGE_FRAMEBUFFER_PLOT_UNIT_ASSERT_SVH
`define MONO_PAGE_FRAMEBUFFER_PLOT_UNIT_ASSERT_SVH

// Clocked check, off while reset is held
`define MPFB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset
`define MPFB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/mpfb_pkg.sv
// Shared constants, codes and bundle types of the framebuffer plot unit.
package mpfb_pkg;

    // Store geometry
    localparam int MAX_COLUMNS  = 128;
    localparam int MAX_PAGES    = 8;
    localparam int PIX_PER_BYTE = 8;
    localparam int MAX_ROWS     = MAX_PAGES * PIX_PER_BYTE;
    localparam int STORE_DEPTH  = MAX_COLUMNS * MAX_PAGES;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);

    // Derived widths
    localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int PAGE_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int SUM_W  = PAGE_W + COL_W + 1;
    localparam int CNT_W  = 4;

    // Fixed field widths
    localparam int PWIDTH_W = 8;
    localparam int PHEIGHT_W = 7;
    localparam int COORD_W  = 16;
    localparam int RIDX_W   = 10;
    localparam int DATA_W   = 8;

    // Register map (word index)
    localparam logic REG_PANEL_WIDTH  = 1'b0;
    localparam logic REG_PANEL_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        CMD_PLOT   = 2'd0,
        CMD_BITMAP = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        COLOR_BLACK  = 2'd0,
        COLOR_WHITE  = 2'd1,
        COLOR_INVERT = 2'd2,
        COLOR_NONE   = 2'd3
    } color_t;

    typedef struct packed {
        logic [PWIDTH_W-1:0]  width;
        logic [PHEIGHT_W-1:0] height;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;      // capture the accepted command
        logic rmw_read;   // read the byte of the current pixel
        logic rmw_write;  // write back the modified byte
        logic next_bit;   // advance to the next bitmap bit
        logic clr_write;  // write zero at the sweep address
        logic rd_issue;   // read the byte for a read command
        logic load_out;   // move the result into the output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic bits_done;
        logic pixel_hit;
        logic clr_last;
        logic out_busy;
    } dp_stat_t;

endpackage

>>> hdl/mpfb_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module mpfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/mpfb_ctrl.sv
// Command sequencer of the framebuffer plot unit.
module mpfb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        command,
    input  mpfb_pkg::dp_stat_t stat,
    output mpfb_pkg::dp_cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_STEP  = 7'b0000100,
        S_WRITE = 7'b0001000,
        S_CLEAR = 7'b0010000,
        S_READ  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    mpfb_pkg::cmd_t op;

    assign op       = mpfb_pkg::cmd_t'(command);
    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.clr_write = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    unique case (op)
                        mpfb_pkg::CMD_PLOT:   state_next = S_STEP;
                        mpfb_pkg::CMD_BITMAP: state_next = S_STEP;
                        mpfb_pkg::CMD_CLEAR:  state_next = S_CLEAR;
                        mpfb_pkg::CMD_READ:   state_next = S_READ;
                        default:              state_next = S_IDLE;
                    endcase
                end
            end
            S_STEP:
            begin
                priority if (stat.bits_done)
                begin
                    state_next = S_DONE;
                end
                else if (stat.pixel_hit)
                begin
                    cmd.rmw_read = 1'b1;
                    state_next   = S_WRITE;
                end
                else
                begin
                    cmd.next_bit = 1'b1;
                end
            end
            S_WRITE:
            begin
                cmd.rmw_write = 1'b1;
                cmd.next_bit  = 1'b1;
                state_next    = S_STEP;
            end
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

>>> hdl/mpfb_dpath.sv
// Datapath: command registers, pixel address and mask, frame store, result register.
module mpfb_dpath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mpfb_pkg::cfg_t                   cfg,
    input  logic [1:0]                       command,
    input  logic [mpfb_pkg::COORD_W-1:0]     x,
    input  logic [mpfb_pkg::COORD_W-1:0]     y,
    input  logic [1:0]                       color,
    input  logic [mpfb_pkg::DATA_W-1:0]      pattern,
    input  logic [3:0]                       pattern_bits,
    input  logic [mpfb_pkg::RIDX_W-1:0]      read_index,
    input  mpfb_pkg::dp_cmd_t                cmd,
    output mpfb_pkg::dp_stat_t               stat,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [mpfb_pkg::DATA_W-1:0]      read_data
);

    localparam int AW  = mpfb_pkg::ADDR_W;
    localparam int CW  = mpfb_pkg::COL_W;
    localparam int RW  = mpfb_pkg::ROW_W;
    localparam int PW  = mpfb_pkg::PAGE_W;
    localparam int SW  = mpfb_pkg::SUM_W;
    localparam int DW  = mpfb_pkg::DATA_W;
    localparam int XW  = mpfb_pkg::COORD_W;
    localparam int NW  = mpfb_pkg::CNT_W;

    // Command fields held for the duration of the command
    logic [XW-1:0]            x_reg, y_reg;
    mpfb_pkg::color_t         color_reg;
    logic [DW-1:0]            pat_reg, pat_next;
    logic [NW-1:0]            nbits_reg;
    logic [mpfb_pkg::RIDX_W-1:0] ridx_reg;
    logic                     is_read_reg;
    logic [AW-1:0]            addr_reg;

    // Control counters
    logic [NW-1:0]            bit_reg, bit_next;
    logic [AW-1:0]            clr_reg, clr_next;
    logic                     out_valid_reg, out_valid_next;
    logic [DW-1:0]            read_data_reg;

    // Effective panel size
    logic [CW-1:0]            w_eff;
    logic [RW-1:0]            h_eff;

    // Pixel address
    logic [XW:0]              px;
    logic                     x_ok, y_ok, idx_ok, ridx_ok;
    logic [PW-1:0]            page;
    logic [PW+CW-1:0]         prod;
    logic [SW-1:0]            idx_full;
    logic [DW-1:0]            mask;

    // RAM ports
    logic                     ram_we, ram_re;
    logic [AW-1:0]            ram_waddr, ram_raddr;
    logic [DW-1:0]            ram_wdata, ram_rdata, rmw_data;

    assign w_eff = (32'(cfg.width) > 32'(mpfb_pkg::MAX_COLUMNS))
                   ? CW'(mpfb_pkg::MAX_COLUMNS) : CW'(cfg.width);
    assign h_eff = (32'(cfg.height) > 32'(mpfb_pkg::MAX_ROWS))
                   ? RW'(mpfb_pkg::MAX_ROWS) : RW'(cfg.height);

    // Column of the current bit, one bit wider to keep the sign
    assign px   = {x_reg[XW-1], x_reg} + (XW+1)'(bit_reg);
    assign x_ok = !px[XW] && (px[XW-1:0] < XW'(w_eff));
    assign y_ok = !y_reg[XW-1] && (y_reg < XW'(h_eff));

    // Byte index = column + page * width
    assign page     = y_reg[PW+2:3];
    assign prod     = (PW+CW)'(page) * (PW+CW)'(w_eff);
    assign idx_full = SW'(px[CW-1:0]) + SW'(prod);
    assign idx_ok   = idx_full < SW'(mpfb_pkg::STORE_DEPTH);
    assign mask     = DW'(1) << y_reg[2:0];
    assign ridx_ok  = 32'(ridx_reg) < 32'(mpfb_pkg::STORE_DEPTH);

    // Modified byte for the write-back
    always_comb
    begin
        unique case (color_reg)
            mpfb_pkg::COLOR_BLACK:  rmw_data = ram_rdata & ~mask;
            mpfb_pkg::COLOR_WHITE:  rmw_data = ram_rdata | mask;
            mpfb_pkg::COLOR_INVERT: rmw_data = ram_rdata ^ mask;
            default:                rmw_data = ram_rdata;
        endcase
    end

    // Status to the controller
    assign stat.bits_done = (bit_reg == nbits_reg);
    assign stat.pixel_hit = pat_reg[DW-1] && x_ok && y_ok && idx_ok
                            && (color_reg != mpfb_pkg::COLOR_NONE);
    assign stat.clr_last  = (clr_reg == AW'(mpfb_pkg::STORE_DEPTH - 1));
    assign stat.out_busy  = out_valid_reg && out_stall;

    // Frame store ports
    assign ram_we    = cmd.clr_write || cmd.rmw_write;
    assign ram_waddr = cmd.clr_write ? clr_reg : addr_reg;
    assign ram_wdata = cmd.clr_write ? '0 : rmw_data;
    assign ram_re    = cmd.rmw_read || cmd.rd_issue;
    assign ram_raddr = cmd.rd_issue ? AW'(ridx_reg) : idx_full[AW-1:0];

    mpfb_ram #(
        .WIDTH (DW),
        .DEPTH (mpfb_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Counter and output next values
    always_comb
    begin
        bit_next       = bit_reg;
        clr_next       = clr_reg;
        pat_next       = pat_reg;
        out_valid_next = out_valid_reg;
        if (cmd.latch)
        begin
            bit_next = '0;
            clr_next = '0;
        end
        if (cmd.next_bit)
        begin
            bit_next = bit_reg + NW'(1);
            pat_next = pat_reg << 1;
        end
        if (cmd.clr_write)
        begin
            clr_next = stat.clr_last ? '0 : clr_reg + AW'(1);
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bit_reg       <= bit_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            x_reg       <= x;
            y_reg       <= y;
            color_reg   <= mpfb_pkg::color_t'(color);
            ridx_reg    <= read_index;
            is_read_reg <= (mpfb_pkg::cmd_t'(command) == mpfb_pkg::CMD_READ);
            // a single plot runs as a one-bit bitmap
            if (mpfb_pkg::cmd_t'(command) == mpfb_pkg::CMD_PLOT)
            begin
                pat_reg   <= DW'(8'h80);
                nbits_reg <= NW'(1);
            end
            else
            begin
                pat_reg   <= pattern;
                nbits_reg <= (pattern_bits > NW'(mpfb_pkg::PIX_PER_BYTE))
                             ? NW'(mpfb_pkg::PIX_PER_BYTE) : pattern_bits;
            end
        end
        else
        begin
            pat_reg <= pat_next;
        end
        if (cmd.rmw_read)
        begin
            addr_reg <= idx_full[AW-1:0];
        end
        if (cmd.load_out)
        begin
            read_data_reg <= (is_read_reg && ridx_ok) ? ram_rdata : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

endmodule

>>> hdl/mono_page_framebuffer_plot_unit.sv
// Top level of the page-organized monochrome framebuffer plot unit.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------------
//  input    | in_valid / in_stall   | command x y color pattern pattern_bits read_index
//  output   | out_valid / out_stall | read_data
//  config   | APB psel/penable      | paddr pwdata prdata
//
// From accept to result in the output register: plot and bitmap step their bits,
//   read issues one store read, clear sweeps the whole store; a drawn
//   pixel is a read then a write. Next command taken in the cycle after the load.
// After reset a clearing pass over all STORE_DEPTH bytes (1024) zeroes the store
// while in_stall is held high; configuration writes are taken meanwhile.
// A stalled output holds the result; the next command is accepted meanwhile.
module mono_page_framebuffer_plot_unit (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [15:0] x,
    input  logic [15:0] y,
    input  logic [1:0]  color,
    input  logic [7:0]  pattern,
    input  logic [3:0]  pattern_bits,
    input  logic [9:0]  read_index,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [mpfb_pkg::PWIDTH_W-1:0]  width_reg;
    logic [mpfb_pkg::PHEIGHT_W-1:0] height_reg;
    logic                           wr_en;
    mpfb_pkg::cfg_t                 cfg;
    mpfb_pkg::dp_cmd_t              dp_cmd;
    mpfb_pkg::dp_stat_t             dp_stat;

    // Register file
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mpfb_pkg::PWIDTH_W'(128);
            height_reg <= mpfb_pkg::PHEIGHT_W'(64);
        end
        else if (wr_en)
        begin
            if (paddr[2] == mpfb_pkg::REG_PANEL_WIDTH)
            begin
                width_reg <= pwdata[mpfb_pkg::PWIDTH_W-1:0];
            end
            else
            begin
                height_reg <= pwdata[mpfb_pkg::PHEIGHT_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == mpfb_pkg::REG_PANEL_HEIGHT)
                    ? 32'(height_reg) : 32'(width_reg);

    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;

    mpfb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    mpfb_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .command      (command),
        .x            (x),
        .y            (y),
        .color        (color),
        .pattern      (pattern),
        .pattern_bits (pattern_bits),
        .read_index   (read_index),
        .cmd          (dp_cmd),
        .stat         (dp_stat),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_data    (read_data)
    );

endmodule

>>> hdl/mpfb_checker.sv
// Port-level checks of the framebuffer plot unit, bound to the top level.
`include "mono_page_framebuffer_plot_unit_assert.svh"

module mpfb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] read_data
);

    // store is being cleared right after reset, so no transfer is taken
    `MPFB_ASSERT_ALWAYS(a_init_stall, $rose(rst_n) |-> in_stall, "input taken during clear pass")

    // one command at a time: an accepted transfer blocks the next cycle
    `MPFB_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall, "back-to-back accept")

    // a new result only appears out of a busy cycle
    `MPFB_ASSERT(a_result_from_busy, $rose(out_valid) |-> $past(in_stall), "result without command")

    // stalled result holds
    `MPFB_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(read_data)), "stalled result changed")

endmodule

bind mono_page_framebuffer_plot_unit mpfb_checker u_mpfb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_data (read_data)
);

>>> tb/mpfb_plot_checker.sv
// Result checker for the framebuffer plot unit: shadow store, expected read data, compare.
`timescale 1ns / 100ps

module mpfb_plot_checker
    import mpfb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [1:0]        command,
    input  logic [15:0]       x,
    input  logic [15:0]       y,
    input  logic [1:0]        color,
    input  logic [7:0]        pattern,
    input  logic [3:0]        pattern_bits,
    input  logic [9:0]        read_index,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [7:0]        read_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int unsigned       mismatches,
    output int unsigned       waiting_results
);

    localparam logic [2:0] ADDR_PANEL_WIDTH  = {REG_PANEL_WIDTH, 2'b00};
    localparam logic [2:0] ADDR_PANEL_HEIGHT = {REG_PANEL_HEIGHT, 2'b00};

    // Shadow of the frame store and of the panel registers
    logic [DATA_W-1:0]    shadow_frame [0:STORE_DEPTH-1];
    logic [PWIDTH_W-1:0]  shadow_width;
    logic [PHEIGHT_W-1:0] shadow_height;

    // Read data owed by the block, oldest first
    logic [DATA_W-1:0]    owed_read_data [$];
    int unsigned          fail_tally;

    // Set, clear or toggle one pixel, dropping it when off the visible panel
    function automatic void paint_dot(input int px, input int py, input color_t shade);
        int cols;
        int rows;
        int idx;
        logic [7:0] bitmask;
        cols = (shadow_width < MAX_COLUMNS) ? int'(shadow_width) : MAX_COLUMNS;
        rows = (shadow_height < MAX_ROWS) ? int'(shadow_height) : MAX_ROWS;
        if (px < 0 || px >= cols || py < 0 || py >= rows)
            return;
        idx = px + (py / PIX_PER_BYTE) * cols;
        if (idx >= STORE_DEPTH)
            return;
        bitmask = 8'h01 << (py % PIX_PER_BYTE);
        case (shade)
            COLOR_BLACK:  shadow_frame[idx] = shadow_frame[idx] & ~bitmask;
            COLOR_WHITE:  shadow_frame[idx] = shadow_frame[idx] | bitmask;
            COLOR_INVERT: shadow_frame[idx] = shadow_frame[idx] ^ bitmask;
            default:      ;
        endcase
    endfunction

    // Apply one command to the shadow store and return the read data it yields
    function automatic logic [DATA_W-1:0] frame_update(
        input cmd_t        op,
        input int          px,
        input int          py,
        input color_t      shade,
        input logic [7:0]  pat,
        input logic [3:0]  nbits,
        input logic [9:0]  ridx
    );
        int count;
        logic [DATA_W-1:0] value;
        value = '0;
        case (op)
            CMD_PLOT: paint_dot(px, py, shade);
            CMD_BITMAP: begin
                // counts above a byte act as a full byte; MSB is leftmost
                count = (nbits > PIX_PER_BYTE) ? PIX_PER_BYTE : int'(nbits);
                for (int i = 0; i < count; i++)
                begin
                    if (pat[7-i])
                        paint_dot(px + i, py, shade);
                end
            end
            CMD_CLEAR: begin
                for (int k = 0; k < STORE_DEPTH; k++)
                    shadow_frame[k] = '0;
            end
            default: begin
                if (ridx < STORE_DEPTH)
                    value = shadow_frame[ridx];
            end
        endcase
        return value;
    endfunction

    // Watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        logic [DATA_W-1:0] due;
        if (!rst_n)
        begin
            for (int k = 0; k < STORE_DEPTH; k++)
                shadow_frame[k] = '0;
            owed_read_data.delete();
            shadow_width    = 8'd128;
            shadow_height   = 7'd64;
            fail_tally      = 0;
            mismatches      <= 0;
            waiting_results <= 0;
        end
        else
        begin
            // register write at the access edge
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == ADDR_PANEL_WIDTH)
                    shadow_width = pwdata[PWIDTH_W-1:0];
                else if (paddr == ADDR_PANEL_HEIGHT)
                    shadow_height = pwdata[PHEIGHT_W-1:0];
            end

            // result transfer against the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (owed_read_data.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got read_data %02h",
                             $time, read_data);
                    fail_tally++;
                end
                else
                begin
                    due = owed_read_data.pop_front();
                    if (read_data !== due)
                    begin
                        $display("%0t: read_data mismatch, expected %02h, got %02h",
                                 $time, due, read_data);
                        fail_tally++;
                    end
                end
            end

            // command transfer: predict its result
            if (in_valid && !in_stall)
                owed_read_data.push_back(frame_update(cmd_t'(command),
                                                      int'($signed(x)), int'($signed(y)),
                                                      color_t'(color), pattern,
                                                      pattern_bits, read_index));

            mismatches      <= fail_tally;
            waiting_results <= owed_read_data.size();
        end
    end

endmodule

>>> tb/tb_top.sv
// Testbench top for the framebuffer plot unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
    import mpfb_pkg::*;

    localparam logic [2:0] ADDR_PANEL_WIDTH  = {REG_PANEL_WIDTH, 2'b00};
    localparam logic [2:0] ADDR_PANEL_HEIGHT = {REG_PANEL_HEIGHT, 2'b00};
    localparam int ITEMS_PER_PHASE = 125;
    localparam int MAX_IDLE        = 17;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [15:0] x;
    logic [15:0] y;
    logic [1:0]  color;
    logic [7:0]  pattern;
    logic [3:0]  pattern_bits;
    logic [9:0]  read_index;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  read_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int unsigned mismatches;
    int unsigned waiting_results;

    // pacing modes: no idling on that side while set
    bit steady_tx;
    bit steady_rx;
    int stall_left;

    mono_page_framebuffer_plot_unit i_dut (.*);

    mpfb_plot_checker i_checker (.*);

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #(25_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    // Receiver: random stall after each result transfer
    always @(posedge clk or negedge rst_n)
    begin : rx_pacing
        int stall_next;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                stall_next = steady_rx ? 0 : $urandom_range(0, MAX_IDLE);
            else if (stall_left != 0)
                stall_next = stall_left - 1;
            else
                stall_next = 0;
            stall_left <= stall_next;
            out_stall  <= (stall_next != 0);
        end
    end

    // One command transfer, after a random gap
    task automatic issue_cmd(
        input cmd_t        op,
        input int          xv,
        input int          yv,
        input color_t      shade,
        input logic [7:0]  pat,
        input logic [3:0]  nbits,
        input logic [9:0]  ridx
    );
        int gap;
        gap = steady_tx ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= op;
        x            <= 16'(xv);
        y            <= 16'(yv);
        color        <= shade;
        pattern      <= pat;
        pattern_bits <= nbits;
        read_index   <= ridx;
        do @(posedge clk); while (in_stall);
    endtask

    // Hold off the sender until every result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (waiting_results != 0);
    endtask

    // Register write: setup then access
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        int     cols;
        int     rows;
        int     sel;
        int     xv;
        int     yv;
        int     last_idx;
        int     wsel;
        int     hsel;
        cmd_t   op;
        color_t shade;
        logic [9:0] ridx;

        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        command      <= CMD_PLOT;
        x            <= '0;
        y            <= '0;
        color        <= COLOR_BLACK;
        pattern      <= '0;
        pattern_bits <= '0;
        read_index   <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        steady_tx    = 1'b0;
        steady_rx    <= 1'b0;
        last_idx     = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on the reset panel size
        issue_cmd(CMD_PLOT, 0, 0, COLOR_WHITE, 8'($urandom), 4'($urandom), 10'($urandom));
        issue_cmd(CMD_READ, $urandom, $urandom, color_t'($urandom), 8'($urandom),
                  4'($urandom), 10'd0);
        // far corner lands in the last byte
        issue_cmd(CMD_PLOT, 127, 63, COLOR_WHITE, 8'($urandom), 4'($urandom), 10'($urandom));
        issue_cmd(CMD_READ, 0, 0, COLOR_NONE, 8'hFF, 4'hF, 10'd1023);
        issue_cmd(CMD_PLOT, 0, 0, COLOR_INVERT, 8'($urandom), 4'($urandom), 10'($urandom));
        issue_cmd(CMD_PLOT, 0, 7, COLOR_INVERT, 8'($urandom), 4'($urandom), 10'($urandom));
        issue_cmd(CMD_READ, 0, 0, COLOR_BLACK, 8'h00, 4'h0, 10'd0);
        // no-change color, then black
        issue_cmd(CMD_PLOT, 0, 7, COLOR_NONE, 8'($urandom), 4'($urandom), 10'($urandom));
        issue_cmd(CMD_READ, 0, 0, COLOR_BLACK, 8'h00, 4'h0, 10'd0);
        issue_cmd(CMD_PLOT, 0, 7, COLOR_BLACK, 8'($urandom), 4'($urandom), 10'($urandom));
        // clipped pixels, coordinate extremes
        issue_cmd(CMD_PLOT, -1, 0, COLOR_WHITE, 8'($urandom), 4'($urandom), 10'($urandom));
        issue_cmd(CMD_PLOT, 128, 5, COLOR_WHITE, 8'($urandom), 4'($urandom), 10'($urandom));
        issue_cmd(CMD_PLOT, 3, 64, COLOR_WHITE, 8'($urandom), 4'($urandom), 10'($urandom));
        issue_cmd(CMD_PLOT, -32768, 32767, COLOR_WHITE, 8'($urandom), 4'($urandom),
                  10'($urandom));
        issue_cmd(CMD_PLOT, 32767, -32768, COLOR_INVERT, 8'($urandom), 4'($urandom),
                  10'($urandom));
        issue_cmd(CMD_READ, 0, 0, COLOR_WHITE, 8'h00, 4'h0, 10'd0);
        // bitmap running off the right edge
        issue_cmd(CMD_BITMAP, 124, 3, COLOR_WHITE, 8'hA5, 4'd8, 10'($urandom));
        issue_cmd(CMD_READ, 0, 0, COLOR_WHITE, 8'h00, 4'h0, 10'd124);
        issue_cmd(CMD_READ, 0, 0, COLOR_WHITE, 8'h00, 4'h0, 10'd126);
        // bit count above a byte, and zero
        issue_cmd(CMD_BITMAP, 10, 60, COLOR_INVERT, 8'hFF, 4'd15, 10'($urandom));
        issue_cmd(CMD_BITMAP, 20, 60, COLOR_WHITE, 8'hFF, 4'd0, 10'($urandom));
        issue_cmd(CMD_READ, 0, 0, COLOR_WHITE, 8'h00, 4'h0, 10'd913);
        issue_cmd(CMD_READ, 0, 0, COLOR_WHITE, 8'h00, 4'h0, 10'd916);
        issue_cmd(CMD_CLEAR, $urandom, $urandom, color_t'($urandom), 8'($urandom),
                  4'($urandom), 10'($urandom));
        issue_cmd(CMD_READ, 0, 0, COLOR_WHITE, 8'h00, 4'h0, 10'd1023);

        // Random phases, each on its own panel size
        for (int ph = 0; ph < 6; ph++)
        begin
            drain_results();
            case (ph)
                0: begin wsel = 128; hsel = 64; end
                1: begin wsel = 1;   hsel = 1;   end
                2: begin wsel = 255; hsel = 127; end
                3: begin wsel = 0;   hsel = 0;   end
                4: begin wsel = $urandom_range(1, 128); hsel = $urandom_range(1, 64); end
                default: begin wsel = $urandom_range(1, 255); hsel = $urandom_range(1, 127); end
            endcase
            write_reg(ADDR_PANEL_WIDTH, 32'(wsel));
            write_reg(ADDR_PANEL_HEIGHT, 32'(hsel));
            cols = (wsel < MAX_COLUMNS) ? wsel : MAX_COLUMNS;
            rows = (hsel < MAX_ROWS) ? hsel : MAX_ROWS;
            steady_tx = (ph == 4) || ($urandom_range(0, 4) == 0);
            steady_rx <= (ph == 4) || ($urandom_range(0, 4) == 0);
            last_idx  = 0;

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 59) == 0)
                    drain_results();

                sel = $urandom_range(0, 199);
                if (sel < 3)
                    op = CMD_CLEAR;
                else if (sel < 83)
                    op = CMD_PLOT;
                else if (sel < 133)
                    op = CMD_BITMAP;
                else
                    op = CMD_READ;

                // mostly near the visible panel, sometimes anywhere
                if ($urandom_range(0, 9) == 0)
                begin
                    xv = int'($signed(16'($urandom)));
                    yv = int'($signed(16'($urandom)));
                end
                else
                begin
                    xv = $urandom_range(0, cols + 7) - 4;
                    yv = $urandom_range(0, rows + 7) - 4;
                end
                shade = color_t'($urandom_range(0, 3));

                if ((op == CMD_PLOT || op == CMD_BITMAP) &&
                    xv >= 0 && xv < cols && yv >= 0 && yv < rows)
                    last_idx = xv + (yv / PIX_PER_BYTE) * cols;

                // reads mostly land where drawing just happened
                if ($urandom_range(0, 2) == 0)
                    ridx = 10'($urandom_range(0, STORE_DEPTH - 1));
                else
                    ridx = 10'(last_idx + $urandom_range(0, 3));

                issue_cmd(op, xv, yv, shade, 8'($urandom), 4'($urandom_range(0, 15)), ridx);
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && waiting_results == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
